// ----- rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication on the rising clock edge, held off while rst is high
`define CHK_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication on the rising clock edge, held off while rst is high
`define CHK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/rscs_pkg.sv -----
package rscs_pkg;

  // sizes
  localparam int DEPTH_DEF = 16;
  localparam int DIM_W     = 13;
  localparam int CRD_W     = 14;
  localparam int BOX_XW    = 15;
  localparam int BOX_WW    = 14;
  localparam int CW        = 19;
  localparam int SAT_W     = 31;
  localparam int PROD_W    = 30;
  localparam int DIV_STEPS = PROD_W / 2;
  localparam int STEP_W    = $clog2(DIV_STEPS);
  localparam int MARG_W    = 26;
  localparam int ROT_W     = 2;
  localparam int CFG_IDX_W = 3;
  localparam int STAT_W    = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_W = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_H = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_W = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_H = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ROTATION = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MARGINS  = 3'd7;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
  localparam logic [STAT_W-1:0] ST_POP_EMPTY  = 2'd1;
  localparam logic [STAT_W-1:0] ST_PUSH_FULL  = 2'd2;

  // rotation codes
  localparam logic [ROT_W-1:0] ROT_0   = 2'd0;
  localparam logic [ROT_W-1:0] ROT_90  = 2'd1;
  localparam logic [ROT_W-1:0] ROT_180 = 2'd2;
  localparam logic [ROT_W-1:0] ROT_270 = 2'd3;

  // result source select
  localparam logic [1:0] SEL_ZERO = 2'd0;
  localparam logic [1:0] SEL_SRC  = 2'd1;
  localparam logic [1:0] SEL_SCL  = 2'd2;

  // saturation bounds
  localparam logic signed [SAT_W-1:0] XY_MIN = SAT_W'(-16384);
  localparam logic signed [SAT_W-1:0] XY_MAX = SAT_W'(16383);
  localparam logic signed [SAT_W-1:0] WH_MAX = SAT_W'(16383);

  // one stack entry
  typedef struct packed {
    logic signed [BOX_XW-1:0] x;
    logic signed [BOX_XW-1:0] y;
    logic [BOX_WW-1:0]        w;
    logic [BOX_WW-1:0]        h;
  } box_t;

  localparam int BOX_W = $bits(box_t);

  // controller to datapath
  typedef struct packed {
    logic              load;
    logic              xform;
    logic              rd_en;
    logic              cnt_dec;
    logic              clip_left;
    logic              clip_right;
    logic              use_top;
    logic              src_top;
    logic              scl_start;
    logic              emit;
    logic [1:0]        emit_sel;
    logic [STAT_W-1:0] emit_status;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic req_pop;
    logic cnt_zero;
    logic cnt_one;
    logic cnt_full;
    logic scale_en;
    logic div_done;
  } stat_t;

  function automatic logic signed [BOX_XW-1:0] sat_xy(input logic signed [SAT_W-1:0] v);
    if (v < XY_MIN) return XY_MIN[BOX_XW-1:0];
    if (v > XY_MAX) return XY_MAX[BOX_XW-1:0];
    return v[BOX_XW-1:0];
  endfunction

  function automatic logic [BOX_WW-1:0] sat_wh(input logic signed [SAT_W-1:0] v);
    if (v < 0) return '0;
    if (v > WH_MAX) return WH_MAX[BOX_WW-1:0];
    return v[BOX_WW-1:0];
  endfunction

endpackage

// ----- rtl/rscs_ram.sv -----
module rscs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/rscs_div.sv -----
module rscs_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [rscs_pkg::BOX_XW-1:0]  value,
  input  logic signed [rscs_pkg::BOX_XW-1:0]  factor,
  input  logic [rscs_pkg::DIM_W-1:0]          dim,
  output logic                                done,
  output logic signed [rscs_pkg::PROD_W-1:0]  term
);

  import rscs_pkg::*;

  localparam logic [1:0] LN_IDLE = 2'd0;
  localparam logic [1:0] LN_ABS  = 2'd1;
  localparam logic [1:0] LN_RUN  = 2'd2;
  localparam logic [1:0] LN_DONE = 2'd3;

  logic [1:0]               phase;
  logic signed [PROD_W-1:0] prod;
  logic [PROD_W-1:0]        mag;
  logic [PROD_W-1:0]        quo;
  logic [DIM_W-1:0]         rem;
  logic [DIM_W-1:0]         dim_r;
  logic                     neg;
  logic [STEP_W-1:0]        step;

  logic [DIM_W:0] r1, r1s, r2, r2s;
  logic           q1, q2;

  // two restoring steps per cycle
  always_comb begin
    r1  = {rem, mag[PROD_W-1]};
    q1  = (r1 >= {1'b0, dim_r});
    r1s = q1 ? (r1 - {1'b0, dim_r}) : r1;
    r2  = {r1s[DIM_W-1:0], mag[PROD_W-2]};
    q2  = (r2 >= {1'b0, dim_r});
    r2s = q2 ? (r2 - {1'b0, dim_r}) : r2;
  end

  // lane sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= LN_IDLE;
    end else begin
      case (phase)
        LN_ABS:  phase <= LN_RUN;
        LN_RUN:  if (step == STEP_W'(DIV_STEPS - 1)) phase <= LN_DONE;
        default: if (start) phase <= LN_ABS;
      endcase
    end
  end

  // multiply, magnitude, then shift-subtract
  always_ff @(posedge clk) begin
    if (start && (phase == LN_IDLE || phase == LN_DONE)) begin
      prod  <= value * factor;
      dim_r <= dim;
    end
    if (phase == LN_ABS) begin
      neg  <= prod[PROD_W-1];
      mag  <= prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
      rem  <= '0;
      quo  <= '0;
      step <= '0;
    end
    if (phase == LN_RUN) begin
      rem  <= r2s[DIM_W-1:0];
      mag  <= {mag[PROD_W-3:0], 2'b00};
      quo  <= {quo[PROD_W-3:0], q1, q2};
      step <= step + STEP_W'(1);
    end
  end

  // truncate toward zero, zero dimension gives a zero term
  assign done = (phase == LN_DONE);
  assign term = (dim_r == '0) ? '0 : (neg ? -$signed(quo) : $signed(quo));

endmodule

// ----- rtl/rscs_ctrl.sv -----
module rscs_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  rscs_pkg::stat_t stat,
  output rscs_pkg::cmd_t  cmd
);

  import rscs_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DISP = 3'd1;
  localparam logic [2:0] S_TOP  = 3'd2;
  localparam logic [2:0] S_CLIP = 3'd3;
  localparam logic [2:0] S_SCL  = 3'd4;
  localparam logic [2:0] S_WAIT = 3'd5;

  logic [2:0]        state, state_next;
  logic              push_new;
  logic [STAT_W-1:0] emit_st;

  assign busy = (state != S_IDLE);

  // next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        if (stat.req_pop) begin
          if (stat.cnt_zero) begin
            cmd.emit        = 1'b1;
            cmd.emit_sel    = SEL_ZERO;
            cmd.emit_status = ST_POP_EMPTY;
            state_next      = S_IDLE;
          end else if (stat.cnt_one) begin
            cmd.cnt_dec     = 1'b1;
            cmd.emit        = 1'b1;
            cmd.emit_sel    = SEL_ZERO;
            cmd.emit_status = ST_OK;
            state_next      = S_IDLE;
          end else begin
            cmd.cnt_dec = 1'b1;
            cmd.rd_en   = 1'b1;
            state_next  = S_TOP;
          end
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.xform  = 1'b1;
          state_next = S_TOP;
        end
      end
      S_TOP: begin
        if (push_new) begin
          cmd.clip_left = 1'b1;
          cmd.use_top   = !stat.cnt_zero;
          state_next    = S_CLIP;
        end else begin
          cmd.src_top = 1'b1;
          state_next  = S_SCL;
        end
      end
      S_CLIP: begin
        cmd.clip_right = 1'b1;
        cmd.use_top    = !stat.cnt_zero;
        state_next     = S_SCL;
      end
      S_SCL: begin
        if (stat.scale_en) begin
          cmd.scl_start = 1'b1;
          state_next    = S_WAIT;
        end else begin
          cmd.emit        = 1'b1;
          cmd.emit_sel    = SEL_SRC;
          cmd.emit_status = emit_st;
          state_next      = S_IDLE;
        end
      end
      S_WAIT: begin
        if (stat.div_done) begin
          cmd.emit        = 1'b1;
          cmd.emit_sel    = SEL_SCL;
          cmd.emit_status = emit_st;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state and request kind
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      push_new <= 1'b0;
      emit_st  <= ST_OK;
    end else begin
      state <= state_next;
      if (state == S_DISP) begin
        push_new <= !stat.req_pop && !stat.cnt_full;
        emit_st  <= (!stat.req_pop && stat.cnt_full) ? ST_PUSH_FULL : ST_OK;
      end
    end
  end

endmodule

// ----- rtl/rscs_dp.sv -----
module rscs_dp #(
  parameter int STACK_DEPTH = rscs_pkg::DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  rscs_pkg::cmd_t                       cmd,
  output rscs_pkg::stat_t                      stat,
  input  logic                                 req_type,
  input  logic signed [rscs_pkg::CRD_W-1:0]    rect_x,
  input  logic signed [rscs_pkg::CRD_W-1:0]    rect_y,
  input  logic [rscs_pkg::DIM_W-1:0]           rect_w,
  input  logic [rscs_pkg::DIM_W-1:0]           rect_h,
  input  logic                                 cfg_wr,
  input  logic [rscs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rscs_pkg::MARG_W-1:0]          cfg_data,
  output logic                                 done,
  output logic signed [rscs_pkg::BOX_XW-1:0]   scissor_x,
  output logic signed [rscs_pkg::BOX_XW-1:0]   scissor_y,
  output logic [rscs_pkg::BOX_WW-1:0]          scissor_w,
  output logic [rscs_pkg::BOX_WW-1:0]          scissor_h,
  output logic                                 clip_active,
  output logic [rscs_pkg::STAT_W-1:0]          status
);

  import rscs_pkg::*;

  localparam int AW    = $clog2(STACK_DEPTH);
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);

  // configuration registers
  logic [DIM_W-1:0]  screen_width, screen_height, window_width, window_height;
  logic [DIM_W-1:0]  offset_x, offset_y;
  logic [ROT_W-1:0]  rotation;
  logic [MARG_W-1:0] margins;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= DIM_W'(640);
      screen_height <= DIM_W'(480);
      window_width  <= DIM_W'(640);
      window_height <= DIM_W'(480);
      offset_x      <= '0;
      offset_y      <= '0;
      rotation      <= ROT_0;
      margins       <= '0;
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_SCREEN_W: screen_width  <= cfg_data[DIM_W-1:0];
        REG_SCREEN_H: screen_height <= cfg_data[DIM_W-1:0];
        REG_WINDOW_W: window_width  <= cfg_data[DIM_W-1:0];
        REG_WINDOW_H: window_height <= cfg_data[DIM_W-1:0];
        REG_OFFSET_X: offset_x      <= cfg_data[DIM_W-1:0];
        REG_OFFSET_Y: offset_y      <= cfg_data[DIM_W-1:0];
        REG_ROTATION: rotation      <= cfg_data[ROT_W-1:0];
        REG_MARGINS:  margins       <= cfg_data;
        default: ;
      endcase
    end
  end

  // request word
  logic                    req_pop;
  logic signed [CRD_W-1:0] rx, ry;
  logic [DIM_W-1:0]        rw, rh;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_pop <= req_type;
      rx      <= rect_x;
      ry      <= rect_y;
      rw      <= rect_w;
      rh      <= rect_h;
    end
  end

  // stack depth
  logic [CNT_W-1:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.clip_right) begin
      cnt <= cnt + CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  // stack memory
  logic [AW-1:0]    raddr;
  logic [BOX_W-1:0] rd_data;
  box_t             rd_box, nb;

  assign raddr  = req_pop ? AW'(cnt - CNT_W'(2)) : AW'(cnt - CNT_W'(1));
  assign rd_box = rd_data;

  rscs_ram #(
    .WIDTH (BOX_W),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.clip_right),
    .waddr (cnt[AW-1:0]),
    .wdata (nb),
    .re    (cmd.rd_en),
    .raddr (raddr),
    .rdata (rd_data)
  );

  // rotation and offset mapping
  logic signed [CW-1:0] sx, sy, sw, sh, ww, wh, ox, oy, lw, lh;
  logic signed [CW-1:0] xbx, xby, xbw, xbh;

  assign sx = CW'(rx);
  assign sy = CW'(ry);
  assign sw = $signed(CW'(screen_width));
  assign sh = $signed(CW'(screen_height));
  assign ww = $signed(CW'(window_width));
  assign wh = $signed(CW'(window_height));
  assign ox = $signed(CW'(offset_x));
  assign oy = $signed(CW'(offset_y));
  assign lw = (rw == '0) ? (sw - sx) : $signed(CW'(rw));
  assign lh = (rh == '0) ? (sh - sy) : $signed(CW'(rh));

  always_comb begin
    case (rotation)
      ROT_0: begin
        xbx = ox + sx;
        xby = oy + sy;
        xbw = lw;
        xbh = lh;
      end
      ROT_90: begin
        xbx = ww - oy - sy - lh;
        xby = ox + sx;
        xbw = lh;
        xbh = lw;
      end
      ROT_180: begin
        xbx = ww - ox - sx - lw;
        xby = wh - oy - sy - lh;
        xbw = lw;
        xbh = lh;
      end
      default: begin
        xbx = oy + sy;
        xby = wh - ox - sx - lw;
        xbw = lh;
        xbh = lw;
      end
    endcase
  end

  // intersection with the current top
  logic signed [CW-1:0] bx, by, bw, bh;
  box_t                 top_box;
  logic signed [CW-1:0] ltx, lty, lbx, lby, lbw, lbh;
  logic signed [CW-1:0] rex, rey, rbw, rbh;

  assign ltx = CW'(rd_box.x);
  assign lty = CW'(rd_box.y);

  always_comb begin
    lbx = bx;
    lbw = bw;
    lby = by;
    lbh = bh;
    if (cmd.use_top && ltx > bx) begin
      lbw = bw + bx - ltx;
      lbx = ltx;
    end
    if (cmd.use_top && lty > by) begin
      lbh = bh + by - lty;
      lby = lty;
    end
  end

  assign rex = CW'(top_box.x) + $signed(CW'(top_box.w));
  assign rey = CW'(top_box.y) + $signed(CW'(top_box.h));

  always_comb begin
    rbw = bw;
    rbh = bh;
    if (cmd.use_top && rex < bx + bw) rbw = rex - bx;
    if (cmd.use_top && rey < by + bh) rbh = rey - by;
    nb.x = sat_xy(SAT_W'(bx));
    nb.y = sat_xy(SAT_W'(by));
    nb.w = sat_wh(SAT_W'(rbw));
    nb.h = sat_wh(SAT_W'(rbh));
  end

  always_ff @(posedge clk) begin
    if (cmd.xform) begin
      bx <= xbx;
      by <= xby;
      bw <= xbw;
      bh <= xbh;
    end else if (cmd.clip_left) begin
      bx      <= lbx;
      by      <= lby;
      bw      <= lbw;
      bh      <= lbh;
      top_box <= rd_box;
    end
  end

  // box to emit
  box_t src;

  always_ff @(posedge clk) begin
    if (cmd.clip_right) begin
      src <= nb;
    end else if (cmd.src_top) begin
      src <= rd_box;
    end
  end

  // margin viewport scaling
  logic [DIM_W-1:0]          mx, my;
  logic signed [BOX_XW-1:0]  kx, ky;
  logic signed [PROD_W-1:0]  term_x, term_y, term_w, term_h;
  logic                      dn_x, dn_y, dn_w, dn_h;
  logic signed [BOX_XW-1:0]  scl_x, scl_y;
  logic [BOX_WW-1:0]         scl_w, scl_h;

  assign mx = margins[DIM_W-1:0];
  assign my = margins[2*DIM_W-1:DIM_W];
  assign kx = $signed({2'b00, screen_width}) - $signed({1'b0, mx, 1'b0});
  assign ky = $signed({2'b00, screen_height}) - $signed({1'b0, my, 1'b0});

  rscs_div u_div_x (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.scl_start),
    .value  (src.x),
    .factor (kx),
    .dim    (screen_width),
    .done   (dn_x),
    .term   (term_x)
  );

  rscs_div u_div_y (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.scl_start),
    .value  (src.y),
    .factor (ky),
    .dim    (screen_height),
    .done   (dn_y),
    .term   (term_y)
  );

  rscs_div u_div_w (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.scl_start),
    .value  ($signed({1'b0, src.w})),
    .factor (kx),
    .dim    (screen_width),
    .done   (dn_w),
    .term   (term_w)
  );

  rscs_div u_div_h (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.scl_start),
    .value  ($signed({1'b0, src.h})),
    .factor (ky),
    .dim    (screen_height),
    .done   (dn_h),
    .term   (term_h)
  );

  assign scl_x = sat_xy(SAT_W'($signed({1'b0, mx})) + SAT_W'(term_x));
  assign scl_y = sat_xy(SAT_W'($signed({1'b0, my})) + SAT_W'(term_y));
  assign scl_w = sat_wh(SAT_W'(term_w));
  assign scl_h = sat_wh(SAT_W'(term_h));

  // result word
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status <= cmd.emit_status;
      case (cmd.emit_sel)
        SEL_SRC: begin
          scissor_x   <= src.x;
          scissor_y   <= src.y;
          scissor_w   <= src.w;
          scissor_h   <= src.h;
          clip_active <= 1'b1;
        end
        SEL_SCL: begin
          scissor_x   <= scl_x;
          scissor_y   <= scl_y;
          scissor_w   <= scl_w;
          scissor_h   <= scl_h;
          clip_active <= 1'b1;
        end
        default: begin
          scissor_x   <= '0;
          scissor_y   <= '0;
          scissor_w   <= '0;
          scissor_h   <= '0;
          clip_active <= 1'b0;
        end
      endcase
    end
  end

  // status to the controller
  assign stat.req_pop  = req_pop;
  assign stat.cnt_zero = (cnt == '0);
  assign stat.cnt_one  = (cnt == CNT_W'(1));
  assign stat.cnt_full = (cnt == CNT_W'(STACK_DEPTH));
  assign stat.scale_en = (mx != '0) && (my != '0);
  assign stat.div_done = dn_x && dn_y && dn_w && dn_h;

endmodule

// ----- rtl/rotated_scissor_clip_stack_top.sv -----
// channel  | handshake            | payload
// ---------+----------------------+---------------------------------------------
// request  | start in, busy out   | req_type, rect_x, rect_y, rect_w, rect_h
// config   | cfg_valid, cfg_ready | cfg_index, cfg_data
// result   | done out (strobe)    | scissor_x/y/w/h, clip_active, status
//
// one word at a time; busy falls in the same cycle as done strobes
// an unscaled push runs DISP, TOP, CLIP, SCL; a pop that leaves entries runs DISP, TOP, SCL
// margin scaling adds the WAIT state: four radix-4 divider lanes, 15 steps each
// rst is synchronous and empties the stack; the stack memory itself is not cleared
// the result is shown for one cycle only, nothing on this side can hold it off
module rotated_scissor_clip_stack_top #(
  parameter int STACK_DEPTH = rscs_pkg::DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                req_type,
  input  logic signed [rscs_pkg::CRD_W-1:0]   rect_x,
  input  logic signed [rscs_pkg::CRD_W-1:0]   rect_y,
  input  logic [rscs_pkg::DIM_W-1:0]          rect_w,
  input  logic [rscs_pkg::DIM_W-1:0]          rect_h,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rscs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rscs_pkg::MARG_W-1:0]         cfg_data,
  output logic                                done,
  output logic signed [rscs_pkg::BOX_XW-1:0]  scissor_x,
  output logic signed [rscs_pkg::BOX_XW-1:0]  scissor_y,
  output logic [rscs_pkg::BOX_WW-1:0]         scissor_w,
  output logic [rscs_pkg::BOX_WW-1:0]         scissor_h,
  output logic                                clip_active,
  output logic [rscs_pkg::STAT_W-1:0]         status
);

  import rscs_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // registers are always writable
  assign cfg_ready = 1'b1;

  rscs_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  rscs_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .req_type    (req_type),
    .rect_x      (rect_x),
    .rect_y      (rect_y),
    .rect_w      (rect_w),
    .rect_h      (rect_h),
    .cfg_wr      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .done        (done),
    .scissor_x   (scissor_x),
    .scissor_y   (scissor_y),
    .scissor_w   (scissor_w),
    .scissor_h   (scissor_h),
    .clip_active (clip_active),
    .status      (status)
  );

endmodule

// ----- rtl/rscs_checker.sv -----
`include "assert_macros.svh"

module rscs_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                start,
  input logic                                busy,
  input logic                                done,
  input logic signed [rscs_pkg::BOX_XW-1:0]  scissor_x,
  input logic signed [rscs_pkg::BOX_XW-1:0]  scissor_y,
  input logic [rscs_pkg::BOX_WW-1:0]         scissor_w,
  input logic [rscs_pkg::BOX_WW-1:0]         scissor_h,
  input logic                                clip_active,
  input logic [rscs_pkg::STAT_W-1:0]         status
);

  import rscs_pkg::*;

  logic scissor_zero;

  // all four scissor fields are zero
  assign scissor_zero = (scissor_x == '0) && (scissor_y == '0) &&
                        (scissor_w == '0) && (scissor_h == '0);

  // a taken request keeps the block busy in the next cycle
  `CHK_NEXT(a_accept_busy, start && !busy, busy, "request taken but busy not raised")

  // one strobe per request, never two in a row
  `CHK_NEXT(a_done_single, done, !done, "result strobe held for two cycles")

  // an empty stack always reports an all-zero scissor
  `CHK_IMPL(a_empty_zero, done && !clip_active, scissor_zero, "nonzero scissor while inactive")

  // overflow is only reported with rectangles on the stack
  `CHK_IMPL(a_full_active, done && status == ST_PUSH_FULL, clip_active, "overflow reported on inactive stack")

  // underflow leaves the stack empty
  `CHK_IMPL(a_under_empty, done && status == ST_POP_EMPTY, !clip_active, "underflow reported on active stack")

endmodule

bind rotated_scissor_clip_stack_top rscs_checker u_chk (.*);

// ----- tb/rotated_scissor_clip_stack_top_tb.sv -----
module rotated_scissor_clip_stack_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rscs_pkg::*;

  localparam int CLIP_DEPTH    = 16;
  localparam int SETTLE_CYCLES = 30;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int PHASES        = 8;
  localparam int PHASE_WORDS   = 210;

  // one scissor word as it leaves the block
  typedef struct packed {
    logic signed [BOX_XW-1:0] x;
    logic signed [BOX_XW-1:0] y;
    logic [BOX_WW-1:0]        w;
    logic [BOX_WW-1:0]        h;
    logic                     active;
    logic [STAT_W-1:0]        st;
  } scissor_t;

  // tracks the clip stack and the scissor words it must produce
  class scissor_tracker;
    logic [DIM_W-1:0]  screen_w = DIM_W'(640);
    logic [DIM_W-1:0]  screen_h = DIM_W'(480);
    logic [DIM_W-1:0]  window_w = DIM_W'(640);
    logic [DIM_W-1:0]  window_h = DIM_W'(480);
    logic [DIM_W-1:0]  off_x = '0;
    logic [DIM_W-1:0]  off_y = '0;
    logic [ROT_W-1:0]  rot = ROT_0;
    logic [MARG_W-1:0] margin_reg = '0;
    box_t              clips [CLIP_DEPTH];
    int                depth_used = 0;
    scissor_t          pending_scissors[$];
    int                mismatches = 0;

    function longint clamp(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function longint scale_term(longint v, longint dim, longint m);
      if (dim == 0) return 0;
      return (v * (dim - 2 * m)) / dim;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [MARG_W-1:0] data);
      case (idx)
        REG_SCREEN_W: screen_w = data[DIM_W-1:0];
        REG_SCREEN_H: screen_h = data[DIM_W-1:0];
        REG_WINDOW_W: window_w = data[DIM_W-1:0];
        REG_WINDOW_H: window_h = data[DIM_W-1:0];
        REG_OFFSET_X: off_x = data[DIM_W-1:0];
        REG_OFFSET_Y: off_y = data[DIM_W-1:0];
        REG_ROTATION: rot = data[ROT_W-1:0];
        REG_MARGINS:  margin_reg = data;
        default: ;
      endcase
    endfunction

    // margin viewport scaling and output saturation
    function scissor_t shape_scissor(box_t b, bit scale, bit active, logic [STAT_W-1:0] st);
      longint   x, y, w, h, mx, my, sw, sh;
      scissor_t s;
      x = $signed(b.x);
      y = $signed(b.y);
      w = b.w;
      h = b.h;
      mx = margin_reg[12:0];
      my = margin_reg[25:13];
      sw = screen_w;
      sh = screen_h;
      if (scale && mx != 0 && my != 0) begin
        x = mx + scale_term(x, sw, mx);
        y = my + scale_term(y, sh, my);
        w = scale_term(w, sw, mx);
        h = scale_term(h, sh, my);
      end
      s.x = BOX_XW'(clamp(x, -16384, 16383));
      s.y = BOX_XW'(clamp(y, -16384, 16383));
      s.w = BOX_WW'(clamp(w, 0, 16383));
      s.h = BOX_WW'(clamp(h, 0, 16383));
      s.active = active;
      s.st = st;
      return s;
    endfunction

    // works out the scissor word for one accepted request
    function void take_request(bit pop, logic signed [CRD_W-1:0] rx,
                               logic signed [CRD_W-1:0] ry,
                               logic [DIM_W-1:0] rw, logic [DIM_W-1:0] rh);
      longint   x, y, w, h, sw, sh, ww, wh, ox, oy, bx, by, bw, bh;
      longint   tx, ty, tw, th;
      box_t     zero_box, t, nb;
      scissor_t r;
      zero_box = '0;
      if (pop) begin
        if (depth_used == 0) begin
          r = shape_scissor(zero_box, 1'b0, 1'b0, ST_POP_EMPTY);
        end else begin
          depth_used--;
          if (depth_used == 0) r = shape_scissor(zero_box, 1'b0, 1'b0, ST_OK);
          else r = shape_scissor(clips[depth_used-1], 1'b1, 1'b1, ST_OK);
        end
      end else if (depth_used >= CLIP_DEPTH) begin
        r = shape_scissor(clips[CLIP_DEPTH-1], 1'b1, 1'b1, ST_PUSH_FULL);
      end else begin
        x = rx; y = ry; w = rw; h = rh;
        sw = screen_w; sh = screen_h; ww = window_w; wh = window_h;
        ox = off_x; oy = off_y;
        // zero size stretches to the screen edge
        if (w == 0) w = sw - x;
        if (h == 0) h = sh - y;
        // logical to window coordinates
        case (rot)
          ROT_0: begin
            bx = ox + x; by = oy + y; bw = w; bh = h;
          end
          ROT_90: begin
            bx = ww - oy - y - h; by = ox + x; bw = h; bh = w;
          end
          ROT_180: begin
            bx = ww - ox - x - w; by = wh - oy - y - h; bw = w; bh = h;
          end
          default: begin
            bx = oy + y; by = wh - ox - x - w; bw = h; bh = w;
          end
        endcase
        // intersect with the current top
        if (depth_used > 0) begin
          t = clips[depth_used-1];
          tx = $signed(t.x); ty = $signed(t.y); tw = t.w; th = t.h;
          if (tx > bx) begin bw += bx - tx; bx = tx; end
          if (ty > by) begin bh += by - ty; by = ty; end
          if (tx + tw < bx + bw) bw = tx + tw - bx;
          if (ty + th < by + bh) bh = ty + th - by;
        end
        if (bw < 0) bw = 0;
        if (bh < 0) bh = 0;
        nb.x = BOX_XW'(clamp(bx, -16384, 16383));
        nb.y = BOX_XW'(clamp(by, -16384, 16383));
        nb.w = BOX_WW'(clamp(bw, 0, 16383));
        nb.h = BOX_WW'(clamp(bh, 0, 16383));
        clips[depth_used] = nb;
        depth_used++;
        r = shape_scissor(nb, 1'b1, 1'b1, ST_OK);
      end
      pending_scissors = {pending_scissors, r};
    endfunction

    // compares one result word with the oldest expected one
    function void check_scissor(scissor_t got);
      scissor_t want;
      if (pending_scissors.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: scissor word with none expected: x=%0d y=%0d w=%0d h=%0d a=%0d st=%0d",
                   $realtime, got.x, got.y, got.w, got.h, got.active, got.st);
        return;
      end
      want = pending_scissors.pop_front();
      if (got.x !== want.x || got.y !== want.y || got.w !== want.w || got.h !== want.h ||
          got.active !== want.active || got.st !== want.st) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: scissor mismatch", $realtime);
          $display("  expected x=%0d y=%0d w=%0d h=%0d a=%0d st=%0d",
                   want.x, want.y, want.w, want.h, want.active, want.st);
          $display("  actual   x=%0d y=%0d w=%0d h=%0d a=%0d st=%0d",
                   got.x, got.y, got.w, got.h, got.active, got.st);
        end
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic                     busy;
  logic                     req_type = 1'b0;
  logic signed [CRD_W-1:0]  rect_x = '0;
  logic signed [CRD_W-1:0]  rect_y = '0;
  logic [DIM_W-1:0]         rect_w = '0;
  logic [DIM_W-1:0]         rect_h = '0;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [MARG_W-1:0]        cfg_data = '0;
  logic                     done;
  logic signed [BOX_XW-1:0] scissor_x;
  logic signed [BOX_XW-1:0] scissor_y;
  logic [BOX_WW-1:0]        scissor_w;
  logic [BOX_WW-1:0]        scissor_h;
  logic                     clip_active;
  logic [STAT_W-1:0]        status;

  scissor_tracker tracker = new();
  int unsigned    cycle_count = 0;

  rotated_scissor_clip_stack_top #(
    .STACK_DEPTH(CLIP_DEPTH)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req_type(req_type),
    .rect_x(rect_x),
    .rect_y(rect_y),
    .rect_w(rect_w),
    .rect_h(rect_h),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .done(done),
    .scissor_x(scissor_x),
    .scissor_y(scissor_y),
    .scissor_w(scissor_w),
    .scissor_h(scissor_h),
    .clip_active(clip_active),
    .status(status)
  );

  always #6 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // observe register writes, result words and accepted requests
  always @(posedge clk) begin : watch
    scissor_t got;
    if (!rst) begin
      if (cfg_valid && cfg_ready) tracker.set_reg(cfg_index, cfg_data);
      if (done) begin
        got.x = scissor_x;
        got.y = scissor_y;
        got.w = scissor_w;
        got.h = scissor_h;
        got.active = clip_active;
        got.st = status;
        tracker.check_scissor(got);
      end
      if (start && !busy) tracker.take_request(req_type, rect_x, rect_y, rect_w, rect_h);
    end
  end

  // present one request word and hold it until taken; start stays high
  task automatic send_request(input bit pop, input logic signed [CRD_W-1:0] x,
                              input logic signed [CRD_W-1:0] y,
                              input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
    start <= 1'b1;
    req_type <= pop;
    rect_x <= x;
    rect_y <= y;
    rect_w <= w;
    rect_h <= h;
    do @(posedge clk); while (busy);
  endtask

  // random gap between request words, mostly short
  task automatic rest(input bit quiet);
    int unsigned r;
    int unsigned n;
    r = $urandom_range(0, 99);
    n = 0;
    if (!quiet) begin
      if (r >= 90) n = $urandom_range(8, 40);
      else if (r >= 55) n = $urandom_range(1, 3);
    end
    if (n != 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // wait until every expected word has come back and the block is quiet
  task automatic drain();
    start <= 1'b0;
    while (tracker.pending_scissors.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one register write; valid stays high for a following write
  task automatic drive_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MARG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic program_regs(input int sw, input int sh, input int ww, input int wh,
                              input int ox, input int oy, input int rot, input int mx,
                              input int my);
    drive_reg(REG_SCREEN_W, MARG_W'(sw));
    drive_reg(REG_SCREEN_H, MARG_W'(sh));
    drive_reg(REG_WINDOW_W, MARG_W'(ww));
    drive_reg(REG_WINDOW_H, MARG_W'(wh));
    drive_reg(REG_OFFSET_X, MARG_W'(ox));
    drive_reg(REG_OFFSET_Y, MARG_W'(oy));
    drive_reg(REG_ROTATION, MARG_W'(rot));
    drive_reg(REG_MARGINS, {13'(my), 13'(mx)});
    cfg_valid <= 1'b0;
  endtask

  // register settings per phase, extremes included
  task automatic apply_setting(input int k);
    case (k)
      0: program_regs(640, 480, 640, 480, 0, 0, ROT_0, 0, 0);
      1: program_regs(480, 640, 640, 480, 8, 16, ROT_90, 20, 15);
      2: program_regs(640, 480, 700, 520, 30, 20, ROT_180, 0, 30);
      3: program_regs(320, 240, 400, 300, 5, 7, ROT_270, 400, 100);
      4: program_regs(8191, 8191, 8191, 8191, 8191, 8191, ROT_270, 8191, 8191);
      5: program_regs(1, 1, 1, 1, 0, 0, ROT_0, 1, 1);
      6: program_regs($urandom_range(1, 8191), $urandom_range(1, 8191),
                      $urandom_range(1, 8191), $urandom_range(1, 8191),
                      $urandom_range(0, 8191), $urandom_range(0, 8191),
                      $urandom_range(0, 3), $urandom_range(0, 8191),
                      $urandom_range(0, 8191));
      default: program_regs($urandom_range(200, 1920), $urandom_range(200, 1080),
                            $urandom_range(200, 1920), $urandom_range(200, 1080),
                            $urandom_range(0, 64), $urandom_range(0, 64),
                            $urandom_range(0, 3), $urandom_range(1, 64),
                            $urandom_range(1, 64));
    endcase
  endtask

  // mostly near the screen, sometimes anywhere in the field range
  function automatic logic signed [CRD_W-1:0] pick_coord();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return CRD_W'($urandom_range(0, 800) - 60);
    if (r < 85) return CRD_W'($urandom);
    case (r % 4)
      0: return -14'sd8192;
      1: return 14'sd8191;
      2: return -14'sd1;
      default: return '0;
    endcase
  endfunction

  function automatic logic [DIM_W-1:0] pick_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 80) return DIM_W'($urandom_range(1, 700));
    if (r < 92) return DIM_W'($urandom);
    return (r % 2) ? 13'd8191 : 13'd1;
  endfunction

  initial begin : stimulus
    int  i;
    int  phase;
    int  push_pct;
    bit  quiet;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: pop on empty, screen-edge stretch, field extremes, fill, push on full
    send_request(1'b1, '0, '0, '0, '0);
    rest(1'b0);
    send_request(1'b0, '0, '0, '0, '0);
    rest(1'b0);
    send_request(1'b0, -14'sd8192, -14'sd8192, 13'd8191, 13'd8191);
    rest(1'b0);
    send_request(1'b0, 14'sd10, 14'sd20, 13'd100, 13'd50);
    rest(1'b0);
    for (i = 3; i < 15; i++) begin
      send_request(1'b0, CRD_W'(i * 3), CRD_W'(i * 2), DIM_W'(110 - i * 6), DIM_W'(60 - i * 3));
      rest(1'b0);
    end
    send_request(1'b0, 14'sd8191, 14'sd8191, '0, '0);
    rest(1'b0);
    send_request(1'b0, 14'sd5, 14'sd5, 13'd5, 13'd5);
    rest(1'b0);
    for (i = 0; i < 3; i++) begin
      send_request(1'b1, '0, '0, '0, '0);
      rest(1'b0);
    end
    drain();

    // random phases, one register setting each
    for (phase = 0; phase < PHASES; phase++) begin
      apply_setting(phase);
      push_pct = (phase % 3 == 0) ? 75 : (phase % 3 == 1) ? 50 : 35;
      quiet = 1'b0;
      for (i = 0; i < PHASE_WORDS; i++) begin
        if (i % 50 == 0) quiet = ($urandom_range(0, 3) == 0);
        send_request($urandom_range(0, 99) >= push_pct, pick_coord(), pick_coord(),
                     pick_size(), pick_size());
        rest(quiet);
      end
      drain();
    end

    if (tracker.mismatches == 0 && tracker.pending_scissors.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/rscs_pkg.sv
rtl/rscs_ram.sv
rtl/rscs_div.sv
rtl/rscs_ctrl.sv
rtl/rscs_dp.sv
rtl/rotated_scissor_clip_stack_top.sv
rtl/rscs_checker.sv
tb/rotated_scissor_clip_stack_top_tb.sv
